FILE: rtl/lav_pkg.sv
// Shared widths, types and constants of the look-at view basis block.
package lav_pkg;

    localparam int WORD_W         = 32;
    localparam int WIDE_W         = 64;
    localparam int DIFF_W         = WORD_W + 1;
    localparam int MAG_W          = WIDE_W - 1;
    localparam int PRE_BITS       = 30;
    localparam int AXIS_FRAC_BITS = 30;
    localparam int SQ_W           = 2 * PRE_BITS;
    localparam int SUM_W          = SQ_W + 2;
    localparam int LEN_W          = PRE_BITS + 1;
    localparam int NUM_W          = PRE_BITS + AXIS_FRAC_BITS + 1;
    localparam int Q_W            = AXIS_FRAC_BITS + 1;
    localparam int REM_W          = LEN_W + 1;
    localparam int BLEN_W         = $clog2(WIDE_W) + 1;
    localparam int GRP_N          = WIDE_W / 8;
    localparam int GRP_AW         = $clog2(GRP_N);
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int CNT_W          = FIFO_AW + 1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [DIFF_W-1:0] t_diff;

    // classified item from the front end
    typedef struct {
        t_word eye   [3];
        t_word hint  [3];
        t_diff d     [3];
        logic  degen;
    } t_item;

    // values that ride alongside a normalize pipeline
    typedef struct {
        t_word eye   [3];
        t_word hint  [3];
        t_word back  [3];
        t_word right [3];
        logic  degen;
    } t_side;

endpackage

FILE: rtl/lav_if.sv
// Input and output channel interfaces of the look-at view basis block.
interface lav_in_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] hint_up_x;
    logic signed [31:0] hint_up_y;
    logic signed [31:0] hint_up_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               hint_up_x, hint_up_y, hint_up_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               hint_up_x, hint_up_y, hint_up_z,
        output ready
    );
endinterface

interface lav_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] ortho_up_x;
    logic signed [31:0] ortho_up_y;
    logic signed [31:0] ortho_up_z;
    logic signed [31:0] back_x;
    logic signed [31:0] back_y;
    logic signed [31:0] back_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;

    modport source (
        output valid, right_x, right_y, right_z, ortho_up_x, ortho_up_y, ortho_up_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        input  ready
    );
    modport sink (
        input  valid, right_x, right_y, right_z, ortho_up_x, ortho_up_y, ortho_up_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        output ready
    );
endinterface

FILE: rtl/lav_front.sv
// Front end: accepts input transactions, forms eye minus target, flags eye at target.
module lav_front
    import lav_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    lav_in_if.sink i_in,
    output logic   o_valid,
    input  logic   i_ready,
    output t_item  o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_take;

    assign i_in.ready = !r_valid || i_ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_item.eye[0]  = i_in.eye_x;
        n_item.eye[1]  = i_in.eye_y;
        n_item.eye[2]  = i_in.eye_z;
        n_item.hint[0] = i_in.hint_up_x;
        n_item.hint[1] = i_in.hint_up_y;
        n_item.hint[2] = i_in.hint_up_z;
        n_item.d[0]    = t_diff'(i_in.eye_x) - t_diff'(i_in.target_x);
        n_item.d[1]    = t_diff'(i_in.eye_y) - t_diff'(i_in.target_y);
        n_item.d[2]    = t_diff'(i_in.eye_z) - t_diff'(i_in.target_z);
        n_item.degen   = (i_in.eye_x == i_in.target_x) && (i_in.eye_y == i_in.target_y)
                      && (i_in.eye_z == i_in.target_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/lav_fifo.sv
// Short queue between the front end and the arithmetic back end.
module lav_fifo
    import lav_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_count != CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    a_cnt_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count missed a pop");

    a_ptr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FIFO_AW'(r_wr - r_rd) == r_count[FIFO_AW-1:0]))
        else $error("queue pointers disagree with count");

endmodule

FILE: rtl/lav_norm.sv
// Pipelined 3-vector normalizer: prescale, square sum, digit-serial sqrt, divide.
module lav_norm
    import lav_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_wide i_vec [3],
    input  t_side i_side,
    output logic  o_valid,
    output t_word o_vec [3],
    output t_side o_side
);

    typedef struct {
        logic [PRE_BITS-1:0] a [3];
        logic [2:0]          neg;
        logic                zero;
        t_side               side;
    } t_carry;

    // stage 1: magnitudes
    logic             r1_v;
    logic [MAG_W-1:0] r1_mag [3];
    logic [2:0]       r1_neg;
    t_side            r1_side;
    logic [MAG_W-1:0] n1_mag [3];
    logic [2:0]       n1_neg;

    // stage 2: OR of magnitudes, byte flags
    logic             r2_v;
    logic [MAG_W-1:0] r2_mag [3];
    logic [2:0]       r2_neg;
    t_side            r2_side;
    logic [MAG_W-1:0] r2_or;
    logic [GRP_N-1:0] r2_grp;
    logic [MAG_W-1:0] n2_or;
    logic [WIDE_W-1:0] w2_or_ext;
    logic [GRP_N-1:0] n2_grp;

    // stage 3: bit length
    logic              r3_v;
    logic [MAG_W-1:0]  r3_mag [3];
    logic [2:0]        r3_neg;
    t_side             r3_side;
    logic [BLEN_W-1:0] r3_blen;
    logic              r3_zero;
    logic [WIDE_W-1:0] w3_or_ext;
    logic [GRP_AW-1:0] w3_grp;
    logic [7:0]        w3_byte;
    logic [3:0]        w3_bit;
    logic [BLEN_W-1:0] n3_blen;

    // stage 4: prescaled magnitudes
    logic   r4_v;
    t_carry r4_c;
    t_carry n4_c;

    // stage 5: squares
    logic            r5_v;
    t_carry          r5_c;
    logic [SQ_W-1:0] r5_sq [3];

    // square root, one result bit per stage
    logic [LEN_W:0]   r_sq_v;
    t_carry           r_sq_c [LEN_W+1];
    logic [SUM_W-1:0] r_sq_n [LEN_W+1];
    logic [SUM_W-1:0] r_sq_r [LEN_W+1];
    logic [SUM_W-1:0] n_sq_n [LEN_W];
    logic [SUM_W-1:0] n_sq_r [LEN_W];
    logic [SUM_W-1:0] w_sq_bit [LEN_W];
    logic [SUM_W-1:0] w_sq_t [LEN_W];

    // divider, one quotient bit per stage
    logic [Q_W:0]     r_dv_v;
    t_carry           r_dv_c   [Q_W+1];
    logic [LEN_W-1:0] r_dv_len [Q_W+1];
    logic [REM_W-1:0] r_dv_rem [Q_W+1][3];
    logic [Q_W-1:0]   r_dv_low [Q_W+1][3];
    logic [Q_W-1:0]   r_dv_q   [Q_W+1][3];
    logic [REM_W-1:0] n_dv_rem [Q_W][3];
    logic [Q_W-1:0]   n_dv_q   [Q_W][3];
    logic [REM_W-1:0] w_dv_t   [Q_W][3];
    logic [LEN_W-1:0] w_len;
    logic [NUM_W-1:0] w_num [3];

    // output
    logic  r_o_v;
    t_word r_o_vec [3];
    t_side r_o_side;
    t_word n_o_vec [3];
    t_word w_qe [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_neg[i] = i_vec[i][WIDE_W-1];
            n1_mag[i] = n1_neg[i] ? MAG_W'(-i_vec[i]) : MAG_W'(i_vec[i]);
        end
    end

    always_comb begin
        n2_or     = r1_mag[0] | r1_mag[1] | r1_mag[2];
        w2_or_ext = WIDE_W'(n2_or);
        for (int g = 0; g < GRP_N; g++) begin
            n2_grp[g] = |w2_or_ext[g*8 +: 8];
        end
    end

    always_comb begin
        w3_or_ext = WIDE_W'(r2_or);
        w3_grp    = '0;
        for (int g = 0; g < GRP_N; g++) begin
            if (r2_grp[g]) begin
                w3_grp = GRP_AW'(g);
            end
        end
        w3_byte = w3_or_ext[{w3_grp, 3'b000} +: 8];
        w3_bit  = '0;
        for (int k = 0; k < 8; k++) begin
            if (w3_byte[k]) begin
                w3_bit = 4'(k + 1);
            end
        end
        n3_blen = BLEN_W'({w3_grp, 3'b000}) + BLEN_W'(w3_bit);
    end

    // top set bit lands on bit PRE_BITS-1
    always_comb begin
        n4_c.neg  = r3_neg;
        n4_c.zero = r3_zero;
        n4_c.side = r3_side;
        for (int i = 0; i < 3; i++) begin
            if (r3_blen > BLEN_W'(PRE_BITS)) begin
                n4_c.a[i] = PRE_BITS'(r3_mag[i] >> (r3_blen - BLEN_W'(PRE_BITS)));
            end else begin
                n4_c.a[i] = PRE_BITS'(r3_mag[i] << (BLEN_W'(PRE_BITS) - r3_blen));
            end
        end
    end

    always_comb begin
        for (int j = 0; j < LEN_W; j++) begin
            w_sq_bit[j] = SUM_W'(1) << (2 * (LEN_W - 1 - j));
            w_sq_t[j]   = r_sq_r[j] + w_sq_bit[j];
            if (r_sq_n[j] >= w_sq_t[j]) begin
                n_sq_n[j] = r_sq_n[j] - w_sq_t[j];
                n_sq_r[j] = (r_sq_r[j] >> 1) + w_sq_bit[j];
            end else begin
                n_sq_n[j] = r_sq_n[j];
                n_sq_r[j] = r_sq_r[j] >> 1;
            end
        end
    end

    // rounding offset len/2 folded into the numerator
    always_comb begin
        w_len = r_sq_r[LEN_W][LEN_W-1:0];
        for (int i = 0; i < 3; i++) begin
            w_num[i] = (NUM_W'(r_sq_c[LEN_W].a[i]) << AXIS_FRAC_BITS) + NUM_W'(w_len >> 1);
        end
    end

    always_comb begin
        for (int j = 0; j < Q_W; j++) begin
            for (int i = 0; i < 3; i++) begin
                w_dv_t[j][i] = {r_dv_rem[j][i][REM_W-2:0], r_dv_low[j][i][Q_W-1-j]};
                n_dv_q[j][i] = r_dv_q[j][i];
                if (w_dv_t[j][i] >= REM_W'(r_dv_len[j])) begin
                    n_dv_rem[j][i]          = w_dv_t[j][i] - REM_W'(r_dv_len[j]);
                    n_dv_q[j][i][Q_W-1-j]   = 1'b1;
                end else begin
                    n_dv_rem[j][i] = w_dv_t[j][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qe[i] = t_word'(r_dv_q[Q_W][i]);
            if (r_dv_c[Q_W].zero) begin
                n_o_vec[i] = '0;
            end else if (r_dv_c[Q_W].neg[i]) begin
                n_o_vec[i] = -w_qe[i];
            end else begin
                n_o_vec[i] = w_qe[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r_sq_v <= '0;
            r_dv_v <= '0;
            r_o_v  <= 1'b0;
        end else if (i_en) begin
            r1_v   <= i_valid;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            r5_v   <= r4_v;
            r_sq_v <= {r_sq_v[LEN_W-1:0], r5_v};
            r_dv_v <= {r_dv_v[Q_W-1:0], r_sq_v[LEN_W]};
            r_o_v  <= r_dv_v[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n1_mag;
            r1_neg  <= n1_neg;
            r1_side <= i_side;

            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_side <= r1_side;
            r2_or   <= n2_or;
            r2_grp  <= n2_grp;

            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
            r3_side <= r2_side;
            r3_blen <= n3_blen;
            r3_zero <= ~|r2_grp;

            r4_c <= n4_c;

            r5_c <= r4_c;
            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= SQ_W'(r4_c.a[i]) * SQ_W'(r4_c.a[i]);
            end

            r_sq_c[0] <= r5_c;
            r_sq_n[0] <= SUM_W'(r5_sq[0]) + SUM_W'(r5_sq[1]) + SUM_W'(r5_sq[2]);
            r_sq_r[0] <= '0;
            for (int j = 0; j < LEN_W; j++) begin
                r_sq_c[j+1] <= r_sq_c[j];
                r_sq_n[j+1] <= n_sq_n[j];
                r_sq_r[j+1] <= n_sq_r[j];
            end

            r_dv_c[0]   <= r_sq_c[LEN_W];
            r_dv_len[0] <= w_len;
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= REM_W'(w_num[i][NUM_W-1:Q_W]);
                r_dv_low[0][i] <= w_num[i][Q_W-1:0];
                r_dv_q[0][i]   <= '0;
            end
            for (int j = 0; j < Q_W; j++) begin
                r_dv_c[j+1]   <= r_dv_c[j];
                r_dv_len[j+1] <= r_dv_len[j];
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[j+1][i] <= n_dv_rem[j][i];
                    r_dv_low[j+1][i] <= r_dv_low[j][i];
                    r_dv_q[j+1][i]   <= n_dv_q[j][i];
                end
            end

            r_o_vec  <= n_o_vec;
            r_o_side <= r_dv_c[Q_W].side;
        end
    end

    assign o_valid = r_o_v;
    assign o_vec   = r_o_vec;
    assign o_side  = r_o_side;

endmodule

FILE: rtl/lav_back.sv
// Back end: three normalizers, two cross products, translation and output register.
module lav_back
    import lav_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    lav_out_if.source  o_out
);

    localparam logic [WIDE_W-1:0] POS_LIM = (WIDE_W'(1) << (WORD_W - 1)) - 1'b1;
    localparam logic [WIDE_W-1:0] NEG_LIM = WIDE_W'(1) << (WORD_W - 1);

    function automatic t_word sat_round(input t_wide s);
        logic [WIDE_W-1:0] m;
        logic [WIDE_W-1:0] q;
        t_word             r;
        m = s[WIDE_W-1] ? WIDE_W'(-s) : WIDE_W'(s);
        q = (m + (WIDE_W'(1) << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS;
        if (s[WIDE_W-1]) begin
            r = (q > NEG_LIM) ? t_word'(NEG_LIM) : t_word'(-q);
        end else begin
            r = (q > POS_LIM) ? t_word'(POS_LIM) : t_word'(q);
        end
        return r;
    endfunction

    logic w_en;

    // back axis
    t_wide w_a_in [3];
    t_side w_a_side_in;
    logic  w_a_v;
    t_word w_a_vec [3];
    t_side w_a_side;

    // right = hint x back
    logic  r_x1_v;
    t_wide r_x1_p [6];
    t_side r_x1_side;
    t_side w_x_side_in;
    logic  r_x2_v;
    t_wide r_x2_vec [3];
    t_side r_x2_side;
    logic  w_b_v;
    t_word w_b_vec [3];
    t_side w_b_side;

    // ortho up = back x right
    logic  r_y1_v;
    t_wide r_y1_p [6];
    t_side r_y1_side;
    t_side w_y_side_in;
    logic  r_y2_v;
    t_wide r_y2_vec [3];
    t_side r_y2_side;
    logic  w_c_v;
    t_word w_c_vec [3];
    t_side w_c_side;

    // translation
    logic  r_s1_v;
    t_wide r_s1_p [3][3];
    t_word r_s1_up [3];
    t_side r_s1_side;
    logic  r_s2_v;
    t_wide r_s2_s [3];
    t_word r_s2_up [3];
    t_side r_s2_side;

    // output register
    logic  r_out_v;
    t_word r_out_rt [3];
    t_word r_out_up [3];
    t_word r_out_bk [3];
    t_word r_out_sh [3];

    assign w_en    = !r_out_v || o_out.ready;
    assign o_ready = w_en;

    always_comb begin
        w_a_side_in.eye   = i_item.eye;
        w_a_side_in.hint  = i_item.hint;
        w_a_side_in.degen = i_item.degen;
        for (int i = 0; i < 3; i++) begin
            w_a_in[i]            = t_wide'(i_item.d[i]);
            w_a_side_in.back[i]  = '0;
            w_a_side_in.right[i] = '0;
        end
    end

    // sideband with the freshly normalized axis filled in
    always_comb begin
        w_x_side_in       = w_a_side;
        w_x_side_in.back  = w_a_vec;
        w_y_side_in       = w_b_side;
        w_y_side_in.right = w_b_vec;
    end

    lav_norm u_norm_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_vec   (w_a_in),
        .i_side  (w_a_side_in),
        .o_valid (w_a_v),
        .o_vec   (w_a_vec),
        .o_side  (w_a_side)
    );

    lav_norm u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_x2_v),
        .i_vec   (r_x2_vec),
        .i_side  (r_x2_side),
        .o_valid (w_b_v),
        .o_vec   (w_b_vec),
        .o_side  (w_b_side)
    );

    lav_norm u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_y2_v),
        .i_vec   (r_y2_vec),
        .i_side  (r_y2_side),
        .o_valid (w_c_v),
        .o_vec   (w_c_vec),
        .o_side  (w_c_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_v  <= 1'b0;
            r_x2_v  <= 1'b0;
            r_y1_v  <= 1'b0;
            r_y2_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_x1_v  <= w_a_v;
            r_x2_v  <= r_x1_v;
            r_y1_v  <= w_b_v;
            r_y2_v  <= r_y1_v;
            r_s1_v  <= w_c_v;
            r_s2_v  <= r_s1_v;
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // hint x back partial products
            r_x1_p[0] <= t_wide'(w_a_side.hint[1]) * t_wide'(w_a_vec[2]);
            r_x1_p[1] <= t_wide'(w_a_side.hint[2]) * t_wide'(w_a_vec[1]);
            r_x1_p[2] <= t_wide'(w_a_side.hint[2]) * t_wide'(w_a_vec[0]);
            r_x1_p[3] <= t_wide'(w_a_side.hint[0]) * t_wide'(w_a_vec[2]);
            r_x1_p[4] <= t_wide'(w_a_side.hint[0]) * t_wide'(w_a_vec[1]);
            r_x1_p[5] <= t_wide'(w_a_side.hint[1]) * t_wide'(w_a_vec[0]);
            r_x1_side <= w_x_side_in;

            r_x2_vec[0] <= r_x1_p[0] - r_x1_p[1];
            r_x2_vec[1] <= r_x1_p[2] - r_x1_p[3];
            r_x2_vec[2] <= r_x1_p[4] - r_x1_p[5];
            r_x2_side   <= r_x1_side;

            // back x right partial products
            r_y1_p[0] <= t_wide'(w_b_side.back[1]) * t_wide'(w_b_vec[2]);
            r_y1_p[1] <= t_wide'(w_b_side.back[2]) * t_wide'(w_b_vec[1]);
            r_y1_p[2] <= t_wide'(w_b_side.back[2]) * t_wide'(w_b_vec[0]);
            r_y1_p[3] <= t_wide'(w_b_side.back[0]) * t_wide'(w_b_vec[2]);
            r_y1_p[4] <= t_wide'(w_b_side.back[0]) * t_wide'(w_b_vec[1]);
            r_y1_p[5] <= t_wide'(w_b_side.back[1]) * t_wide'(w_b_vec[0]);
            r_y1_side <= w_y_side_in;

            r_y2_vec[0] <= r_y1_p[0] - r_y1_p[1];
            r_y2_vec[1] <= r_y1_p[2] - r_y1_p[3];
            r_y2_vec[2] <= r_y1_p[4] - r_y1_p[5];
            r_y2_side   <= r_y1_side;

            // axis times eye
            for (int k = 0; k < 3; k++) begin
                r_s1_p[0][k] <= t_wide'(w_c_side.right[k]) * t_wide'(w_c_side.eye[k]);
                r_s1_p[1][k] <= t_wide'(w_c_vec[k]) * t_wide'(w_c_side.eye[k]);
                r_s1_p[2][k] <= t_wide'(w_c_side.back[k]) * t_wide'(w_c_side.eye[k]);
            end
            r_s1_up   <= w_c_vec;
            r_s1_side <= w_c_side;

            for (int a = 0; a < 3; a++) begin
                r_s2_s[a] <= -(r_s1_p[a][0] + r_s1_p[a][1] + r_s1_p[a][2]);
            end
            r_s2_up   <= r_s1_up;
            r_s2_side <= r_s1_side;

            for (int k = 0; k < 3; k++) begin
                if (r_s2_side.degen) begin
                    r_out_rt[k] <= '0;
                    r_out_up[k] <= '0;
                    r_out_bk[k] <= '0;
                    r_out_sh[k] <= '0;
                end else begin
                    r_out_rt[k] <= r_s2_side.right[k];
                    r_out_up[k] <= r_s2_up[k];
                    r_out_bk[k] <= r_s2_side.back[k];
                    r_out_sh[k] <= sat_round(r_s2_s[k]);
                end
            end
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.right_x    = r_out_rt[0];
    assign o_out.right_y    = r_out_rt[1];
    assign o_out.right_z    = r_out_rt[2];
    assign o_out.ortho_up_x = r_out_up[0];
    assign o_out.ortho_up_y = r_out_up[1];
    assign o_out.ortho_up_z = r_out_up[2];
    assign o_out.back_x     = r_out_bk[0];
    assign o_out.back_y     = r_out_bk[1];
    assign o_out.back_z     = r_out_bk[2];
    assign o_out.shift_x    = r_out_sh[0];
    assign o_out.shift_y    = r_out_sh[1];
    assign o_out.shift_z    = r_out_sh[2];

endmodule

FILE: rtl/look_at_view_matrix.sv
// Top level of the look-at view basis block: front end, queue, arithmetic back end.
//
//  channel | dir | handshake     | payload
//  i_in    | in  | valid / ready | eye, target, hint_up xyz, Q16.16
//  o_out   | out | valid / ready | right, ortho_up, back (Q1.30), shift (Q16.16)
//
// One transaction per cycle sustained while the output is not stalled; each
// normalizer is a 70-stage pipeline (sqrt and divide each resolve one bit per
// stage).
// Reset is synchronous and clears only valid, pointer and count state.
// A stalled output freezes the back end in place; the front register and the
// 4-entry queue keep taking transactions until the queue fills.
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    lav_in_if.sink    i_in,
    lav_out_if.source o_out
);

    logic  w_f_valid;
    logic  w_f_ready;
    t_item w_f_item;
    logic  w_q_valid;
    logic  w_q_ready;
    t_item w_q_item;

    // forms eye - target and the eye-at-target flag
    lav_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_item  (w_f_item)
    );

    // decouples input acceptance from back-end stalls
    lav_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    // normalize, cross, normalize, cross, normalize, translate
    lav_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_item  (w_q_item),
        .o_out   (o_out)
    );

endmodule
